@@ hdl/srrw_pkg.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// srrw_pkg: shared definitions for the selective-repeat receive window
// Widths, limits, register indexes and the transaction types passed
// between the input stage, the window core and the output stage.
// ---------------------------------------------------------------------------
package srrw_pkg;

    localparam int SEQ_BITS    = 16;
    localparam int MAX_PAYLOAD = 1024;
    localparam int WINDOW_MAX  = 32;

    localparam int PORT_W     = 16;
    localparam int LEN_W      = 11;
    localparam int NEXT_W     = SEQ_BITS + 1;
    localparam int WIN_IDX_W  = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int RUN_W      = $clog2(WINDOW_MAX + 1);
    localparam int OFFSET_W   = 26;
    localparam int BYTES_W    = 27;
    localparam int PROD_W     = SEQ_BITS + 17;

    localparam int WIN_CFG_W  = 6;
    localparam int BUF_CFG_W  = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BUFFER = 2'd1;

    localparam logic [WIN_CFG_W-1:0] WINDOW_RESET = 6'd4;
    localparam logic [BUF_CFG_W-1:0] BUFFER_RESET = 16'd64;

    typedef struct packed {
        logic [PORT_W-1:0]   src_port;
        logic [SEQ_BITS-1:0] seq_number;
        logic [LEN_W-1:0]    payload_length;
        logic                last_frame;
        logic                frame_bad;
    } item_t;

    typedef struct packed {
        logic [PORT_W-1:0]   ack_port;
        logic [SEQ_BITS-1:0] ack_seq;
        logic                ack_error;
        logic                store_payload;
        logic [OFFSET_W-1:0] store_offset;
        logic                transfer_complete;
        logic [BYTES_W-1:0]  total_bytes;
    } result_t;

    // Handshake status between a stage and the flow control in the top level
    typedef struct packed {
        logic full;
        logic advance;
    } stage_ctrl_t;

endpackage
`default_nettype wire

@@ hdl/srrw_in_stage.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// srrw_in_stage: input register for frame headers
// Holds one accepted header until the window core consumes it.
// ---------------------------------------------------------------------------
module srrw_in_stage
    import srrw_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_valid,
    output logic       in_stall,
    input  wire item_t in_item,
    input  wire logic  advance,
    output logic       full,
    output item_t      item
);

    logic  full_reg;
    logic  full_next;
    item_t item_reg;
    logic  load;

    assign in_stall  = full_reg && !advance;
    assign load      = in_valid && !in_stall;
    assign full_next = load || (full_reg && !advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= 1'b0;
        end
        else
        begin
            full_reg <= full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= in_item;
        end
    end

    assign full = full_reg;
    assign item = item_reg;

endmodule
`default_nettype wire

@@ hdl/srrw_window_core.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// srrw_window_core: receive window state and per-frame update
// Keeps the configuration, next expected sequence, received mask and
// transfer counts; works out one result per consumed header.
// ---------------------------------------------------------------------------
module srrw_window_core
    import srrw_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_write,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  step,
    input  wire item_t                 item,
    output result_t                    result
);

    logic [WIN_CFG_W-1:0]  window_reg;
    logic [NEXT_W-1:0]     next_exp_reg,  next_exp_next;
    logic [WINDOW_MAX-1:0] mask_reg,      mask_next;
    logic [NEXT_W-1:0]     frames_reg,    frames_next;
    logic [BYTES_W-1:0]    bytes_reg,     bytes_next;
    logic                  done_reg,      done_next;

    logic [RUN_W-1:0]      eff_w;
    logic [NEXT_W:0]       win_end;
    logic                  in_window;
    logic                  is_next;
    logic                  is_ahead;
    logic [NEXT_W-1:0]     idx_full;
    logic [WIN_IDX_W-1:0]  idx;
    logic [RUN_W-1:0]      run;
    logic [WINDOW_MAX-1:0] mask_slid;
    logic [PROD_W-1:0]     offset_full;
    logic [PROD_W-1:0]     buf_prod;
    logic                  store;

    // Zero means a single frame; clamp above the mask size
    always_comb
    begin
        if (window_reg == '0)
        begin
            eff_w = RUN_W'(1);
        end
        else if (int'(window_reg) > WINDOW_MAX)
        begin
            eff_w = RUN_W'(WINDOW_MAX);
        end
        else
        begin
            eff_w = RUN_W'(window_reg);
        end
    end

    assign win_end     = {1'b0, next_exp_reg} + (NEXT_W + 1)'(eff_w);
    assign in_window   = !item.frame_bad && ((NEXT_W + 1)'(item.seq_number) < win_end);
    assign is_next     = NEXT_W'(item.seq_number) == next_exp_reg;
    assign is_ahead    = NEXT_W'(item.seq_number) > next_exp_reg;
    assign idx_full    = NEXT_W'(item.seq_number) - next_exp_reg;
    assign idx         = idx_full[WIN_IDX_W-1:0];
    assign offset_full = PROD_W'(item.seq_number) * PROD_W'(MAX_PAYLOAD);
    assign buf_prod    = PROD_W'(cfg_data[BUF_CFG_W-1:0]) * PROD_W'(MAX_PAYLOAD);

    // Slide distance: first unreceived slot above the head, else the window length
    always_comb
    begin
        run = eff_w;
        for (int i = WINDOW_MAX - 1; i >= 1; i--)
        begin
            if ((i < int'(eff_w)) && !mask_reg[i])
            begin
                run = RUN_W'(i);
            end
        end
    end

    assign mask_slid = mask_reg >> run;

    always_comb
    begin
        next_exp_next = next_exp_reg;
        mask_next     = mask_reg;
        frames_next   = frames_reg;
        bytes_next    = bytes_reg;
        store         = 1'b0;
        if (!done_reg && in_window)
        begin
            if (is_next)
            begin
                store         = 1'b1;
                mask_next     = mask_slid;
                next_exp_next = next_exp_reg + NEXT_W'(run);
            end
            else if (is_ahead && !mask_reg[idx])
            begin
                store          = 1'b1;
                mask_next[idx] = 1'b1;
            end
            if (item.last_frame)
            begin
                bytes_next  = BYTES_W'(offset_full + PROD_W'(item.payload_length));
                frames_next = NEXT_W'(item.seq_number) + NEXT_W'(1);
            end
        end
        done_next = done_reg || (next_exp_next >= frames_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg   <= WINDOW_RESET;
            next_exp_reg <= '0;
            mask_reg     <= '0;
            frames_reg   <= NEXT_W'(BUFFER_RESET);
            bytes_reg    <= BYTES_W'(PROD_W'(BUFFER_RESET) * PROD_W'(MAX_PAYLOAD));
            done_reg     <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_WINDOW:
                begin
                    window_reg <= cfg_data[WIN_CFG_W-1:0];
                end
                REG_BUFFER:
                begin
                    frames_reg <= NEXT_W'(cfg_data[BUF_CFG_W-1:0]);
                    bytes_reg  <= BYTES_W'(buf_prod);
                end
                default:
                begin
                end
            endcase
        end
        else if (step)
        begin
            next_exp_reg <= next_exp_next;
            mask_reg     <= mask_next;
            frames_reg   <= frames_next;
            bytes_reg    <= bytes_next;
            done_reg     <= done_next;
        end
    end

    always_comb
    begin
        result.ack_port          = item.src_port;
        result.ack_seq           = item.seq_number;
        result.ack_error         = item.frame_bad;
        result.store_payload     = store;
        result.store_offset      = store ? OFFSET_W'(offset_full) : '0;
        result.transfer_complete = done_next;
        result.total_bytes       = done_next ? bytes_next : '0;
    end

endmodule
`default_nettype wire

@@ hdl/srrw_out_stage.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// srrw_out_stage: result register
// Captures one acknowledgement and holds it while the receiver stalls.
// ---------------------------------------------------------------------------
module srrw_out_stage
    import srrw_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire stage_ctrl_t ctrl,
    input  wire result_t     result_in,
    input  wire logic        out_stall,
    output logic             out_valid,
    output result_t          result
);

    logic    full_reg;
    logic    full_next;
    result_t result_reg;

    assign full_next = ctrl.advance || (full_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= 1'b0;
        end
        else
        begin
            full_reg <= full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.advance)
        begin
            result_reg <= result_in;
        end
    end

    assign out_valid = full_reg;
    assign result    = result_reg;

endmodule
`default_nettype wire

@@ hdl/selective_repeat_receive_window_unit.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// selective_repeat_receive_window_unit: selective-repeat receiver window
// Takes parsed frame headers and returns one acknowledgement with a store
// command per frame, tracking the window and the transfer completion.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel: in_valid / in_stall with one frame header per transaction.
//   Output channel: out_valid / out_stall with one acknowledgement, store
//   command and completion status per transaction.
//   Configuration: cfg_write with cfg_index 0 sets the window length, index 1
//   the expected frame count (this also reloads the frame and byte counts).
//   Write configuration only while no transaction is in flight.
// Pipeline and throughput:
//   A header accepted into the input register moves through the window core
//   into the result register. One header per cycle is sustained while
//   out_stall is low: the window update (run-of-ones search, mask shift,
//   compare) is combinational between the input and result registers.
// Reset:
//   Window length 4, expected frame count 64, empty mask, next expected 0.
// Stall:
//   While out_stall is high the result register holds; one more header may
//   wait in the input register, after which in_stall rises.
// ---------------------------------------------------------------------------
module selective_repeat_receive_window_unit
    import srrw_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_write,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [PORT_W-1:0]     src_port,
    input  wire logic [SEQ_BITS-1:0]   seq_number,
    input  wire logic [LEN_W-1:0]      payload_length,
    input  wire logic                  last_frame,
    input  wire logic                  frame_bad,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic [PORT_W-1:0]          ack_port,
    output logic [SEQ_BITS-1:0]        ack_seq,
    output logic                       ack_error,
    output logic                       store_payload,
    output logic [OFFSET_W-1:0]        store_offset,
    output logic                       transfer_complete,
    output logic [BYTES_W-1:0]         total_bytes
);

    item_t       in_item;
    item_t       held_item;
    logic        in_full;
    stage_ctrl_t ctrl;
    result_t     core_result;
    result_t     out_result;

    assign in_item.src_port       = src_port;
    assign in_item.seq_number     = seq_number;
    assign in_item.payload_length = payload_length;
    assign in_item.last_frame     = last_frame;
    assign in_item.frame_bad      = frame_bad;

    // Advance the held header when the result register is free or being taken
    assign ctrl.full    = in_full;
    assign ctrl.advance = in_full && (!out_valid || !out_stall);

    srrw_in_stage u_in_stage
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_item  (in_item),
        .advance  (ctrl.advance),
        .full     (in_full),
        .item     (held_item)
    );

    // Update the window state only on the cycle the header moves on
    srrw_window_core u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .step      (ctrl.advance),
        .item      (held_item),
        .result    (core_result)
    );

    srrw_out_stage u_out_stage
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .result_in (core_result),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .result    (out_result)
    );

    assign ack_port          = out_result.ack_port;
    assign ack_seq           = out_result.ack_seq;
    assign ack_error         = out_result.ack_error;
    assign store_payload     = out_result.store_payload;
    assign store_offset      = out_result.store_offset;
    assign transfer_complete = out_result.transfer_complete;
    assign total_bytes       = out_result.total_bytes;

endmodule
`default_nettype wire

@@ hdl/srrw_checker.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// srrw_checker: port-level checks for the receive window unit
// Watches the output transactions for hold behaviour and field consistency.
// ---------------------------------------------------------------------------
module srrw_checker
    import srrw_pkg::*;
(
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  out_valid,
    input wire logic                  out_stall,
    input wire logic [SEQ_BITS-1:0]   ack_seq,
    input wire logic                  ack_error,
    input wire logic                  store_payload,
    input wire logic [OFFSET_W-1:0]   store_offset,
    input wire logic                  transfer_complete,
    input wire logic [BYTES_W-1:0]    total_bytes
);

    // Hold a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(ack_seq) && $stable(store_offset)
            && $stable(total_bytes) && $stable(store_payload))
    else $error("stalled result changed");

    // Store offset follows the acknowledged sequence
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && store_payload |->
            store_offset == OFFSET_W'(PROD_W'(ack_seq) * PROD_W'(MAX_PAYLOAD)))
    else $error("store offset does not match sequence");

    // Drop offset and byte count when they do not apply
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (store_payload || store_offset == '0)
            && (transfer_complete || total_bytes == '0))
    else $error("inactive field not zero");

    // A bad frame is never stored
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && ack_error |-> !store_payload)
    else $error("error frame stored");

endmodule

bind selective_repeat_receive_window_unit srrw_checker u_srrw_checker (.*);
`default_nettype wire
